FILE: rtl/core/timestamped_sample_ring_overwrite_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the timestamped sample ring
// Clocked on clk, disabled while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef TIMESTAMPED_SAMPLE_RING_OVERWRITE_MACROS_SVH
`define TIMESTAMPED_SAMPLE_RING_OVERWRITE_MACROS_SVH

// Same-cycle implication
`define TSRO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TSRO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tsro_pkg.sv
// -----------------------------------------------------------------------------
// tsro_pkg
// Shared constants and types of the timestamped sample ring.
// -----------------------------------------------------------------------------
package tsro_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int OP_W   = 3;
    localparam int TIME_W = 32;
    localparam int MASK_W = 4;
    localparam int ENTRY_W = TIME_W + MASK_W;
    localparam int CNT_W  = 32;

    localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP       = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BOUND = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_START     = 3'd4;

    // Commands from the request sequencer to the pointer block
    typedef struct packed {
        logic clear;
        logic start;
        logic push;
        logic pop;
    } ptr_cmd_t;

endpackage

FILE: rtl/core/tsro_ram.sv
// -----------------------------------------------------------------------------
// tsro_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module tsro_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/tsro_ptrs.sv
// -----------------------------------------------------------------------------
// tsro_ptrs
// Ring pointers, fill count, overwrite counter and sampling enable.
// -----------------------------------------------------------------------------
module tsro_ptrs #(
    parameter int QUEUE_DEPTH = tsro_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsro_pkg::ptr_cmd_t               cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   write_slot,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   read_slot,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] held,
    output logic [tsro_pkg::CNT_W-1:0]       dropped,
    output logic                             enabled,
    output logic                             full
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int HW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [HW-1:0] FULL_CNT  = HW'(QUEUE_DEPTH);

    logic [AW-1:0]              wr_slot_reg, wr_slot_next;
    logic [AW-1:0]              rd_slot_reg, rd_slot_next;
    logic [HW-1:0]              held_reg, held_next;
    logic [tsro_pkg::CNT_W-1:0] dropped_reg, dropped_next;
    logic                       enabled_reg, enabled_next;

    function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign full = (held_reg == FULL_CNT);

    always_comb
    begin
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        held_next    = held_reg;
        dropped_next = dropped_reg;
        enabled_next = enabled_reg;
        if (cmd.clear)
        begin
            wr_slot_next = '0;
            rd_slot_next = '0;
            held_next    = '0;
            dropped_next = '0;
            if (cmd.start)
            begin
                enabled_next = 1'b1;
            end
        end
        else if (cmd.push)
        begin
            wr_slot_next = step_slot(wr_slot_reg);
            if (full)
            begin
                // drop the oldest entry
                rd_slot_next = step_slot(rd_slot_reg);
                dropped_next = dropped_reg + 1'b1;
            end
            else
            begin
                held_next = held_reg + 1'b1;
            end
        end
        else if (cmd.pop)
        begin
            rd_slot_next = step_slot(rd_slot_reg);
            held_next    = held_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            held_reg    <= '0;
            dropped_reg <= '0;
            enabled_reg <= 1'b0;
        end
        else
        begin
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            held_reg    <= held_next;
            dropped_reg <= dropped_next;
            enabled_reg <= enabled_next;
        end
    end

    assign write_slot = wr_slot_reg;
    assign read_slot  = rd_slot_reg;
    assign held       = held_reg;
    assign dropped    = dropped_reg;
    assign enabled    = enabled_reg;

endmodule

FILE: rtl/core/timestamped_sample_ring_overwrite.sv
// -----------------------------------------------------------------------------
// timestamped_sample_ring_overwrite
// Ring queue of timestamped 4-bit line masks that overwrites its oldest entry.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: opcode,
//   sample_time, sensor_pins, bound_time. Output channel (out_valid /
//   out_stall) returns exactly one result per request: entry_valid,
//   entry_time, entry_mask, overwrite_total and fill_level after the request.
//   Samples are ignored until a clear-and-start request; a sample on a full
//   queue drops the oldest entry and bumps overwrite_total.
//   A result is registered after acceptance; a pop that finds an entry
//   first passes the read state for the registered read of the entry RAM.
//   Throughput: one request per cycle while the receiver does not stall;
//   a pop that finds an entry holds off new requests in the read state.
//   While the receiver stalls, the result register holds and in_stall rises,
//   so at most one result waits. A result taken in a cycle frees the slot for
//   a new request in the same cycle.
//   Reset clears pointers, fill count, counter and enable; RAM contents stay
//   undefined and are read only after being written.
// -----------------------------------------------------------------------------
module timestamped_sample_ring_overwrite #(
    parameter int QUEUE_DEPTH = tsro_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tsro_pkg::OP_W-1:0]        opcode,
    input  logic [tsro_pkg::TIME_W-1:0]      sample_time,
    input  logic [tsro_pkg::MASK_W-1:0]      sensor_pins,
    input  logic [tsro_pkg::TIME_W-1:0]      bound_time,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             entry_valid,
    output logic [tsro_pkg::TIME_W-1:0]      entry_time,
    output logic [tsro_pkg::MASK_W-1:0]      entry_mask,
    output logic [tsro_pkg::CNT_W-1:0]       overwrite_total,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_level
);

    `include "timestamped_sample_ring_overwrite_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int HW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = tsro_pkg::TIME_W;
    localparam int MW = tsro_pkg::MASK_W;

    // Sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;

    tsro_pkg::ptr_cmd_t cmd;
    logic [AW-1:0]      write_slot;
    logic [AW-1:0]      read_slot;
    logic [HW-1:0]      held;
    logic [tsro_pkg::CNT_W-1:0] dropped;
    logic               enabled;
    logic               full;

    logic [tsro_pkg::ENTRY_W-1:0] rd_data;

    logic accept;
    logic out_take;
    logic is_pop;
    logic read_go;

    // Request fields kept across the RAM read
    logic          bound_op_reg;
    logic [TW-1:0] bound_reg;

    logic [TW-1:0] rd_time;
    logic [MW-1:0] rd_mask;
    logic [TW-1:0] diff;
    logic          later;
    logic          release_ok;

    logic          out_valid_reg, out_valid_next;
    logic          ent_valid_reg, ent_valid_next;
    logic [TW-1:0] ent_time_reg, ent_time_next;
    logic [MW-1:0] ent_mask_reg, ent_mask_next;

    // Hold new requests during a RAM read and while a result waits stalled
    assign in_stall = (state_reg == ST_READ) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    assign is_pop  = (opcode == tsro_pkg::OP_POP) || (opcode == tsro_pkg::OP_POP_BOUND);
    assign read_go = accept && is_pop && (held != '0);

    // Wrap-safe compare: entry is later when (entry - bound) is positive
    assign rd_time    = rd_data[tsro_pkg::ENTRY_W-1:MW];
    assign rd_mask    = rd_data[MW-1:0];
    assign diff       = rd_time - bound_reg;
    assign later      = (diff != '0) && !diff[TW-1];
    assign release_ok = !bound_op_reg || !later;

    always_comb
    begin
        cmd.clear = accept && ((opcode == tsro_pkg::OP_CLEAR) ||
                               (opcode == tsro_pkg::OP_START));
        cmd.start = accept && (opcode == tsro_pkg::OP_START);
        cmd.push  = accept && (opcode == tsro_pkg::OP_SAMPLE) && enabled;
        cmd.pop   = (state_reg == ST_READ) && release_ok;
    end

    tsro_ptrs #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ptrs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .write_slot (write_slot),
        .read_slot  (read_slot),
        .held       (held),
        .dropped    (dropped),
        .enabled    (enabled),
        .full       (full)
    );

    // Entry store: {time, mask}, mask already inverted to active high
    tsro_ram #(
        .WIDTH (tsro_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (write_slot),
        .wr_data ({sample_time, ~sensor_pins}),
        .rd_en   (read_go),
        .rd_addr (read_slot),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_take;
        ent_valid_next = ent_valid_reg;
        ent_time_next  = ent_time_reg;
        ent_mask_next  = ent_mask_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (read_go)
                begin
                    // wait in ST_READ for the registered RAM read
                    state_next = ST_READ;
                end
                else if (accept)
                begin
                    // no entry to return: answer at once
                    out_valid_next = 1'b1;
                    ent_valid_next = 1'b0;
                    ent_time_next  = '0;
                    ent_mask_next  = '0;
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                ent_valid_next = release_ok;
                ent_time_next  = release_ok ? rd_time : '0;
                ent_mask_next  = release_ok ? rd_mask : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_valid_reg <= ent_valid_next;
        ent_time_reg  <= ent_time_next;
        ent_mask_reg  <= ent_mask_next;
        if (read_go)
        begin
            bound_op_reg <= (opcode == tsro_pkg::OP_POP_BOUND);
            bound_reg    <= bound_time;
        end
    end

    // Counters update at the same edge the result appears and hold while it waits
    assign out_valid       = out_valid_reg;
    assign entry_valid     = ent_valid_reg;
    assign entry_time      = ent_time_reg;
    assign entry_mask      = ent_mask_reg;
    assign overwrite_total = dropped;
    assign fill_level      = held;

    `TSRO_ASSERT_NOW(a_fill_bound, 1'b1, held <= HW'(QUEUE_DEPTH),
        "fill count beyond queue depth")
    `TSRO_ASSERT_NOW(a_read_slot_free, state_reg == ST_READ, !out_valid_reg,
        "result register busy when read data arrives")
    `TSRO_ASSERT_NEXT(a_overwrite_count, cmd.push && full,
        (dropped == $past(dropped) + 1'b1) && full,
        "overwrite on full queue not counted")
    `TSRO_ASSERT_NEXT(a_empty_pop, accept && is_pop && (held == '0),
        (state_reg == ST_IDLE) && out_valid_reg && !ent_valid_reg,
        "pop on empty queue returned an entry")

endmodule

FILE: verif/tb_timestamped_sample_ring_overwrite.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_timestamped_sample_ring_overwrite
// Self-checking bench for the overwriting ring of timestamped line masks.
// A short table of requests covers the corner cases: empty pops, samples
// before start, unused opcodes, timestamp extremes and the wrap-safe time
// bound. Several hundred random requests follow, grouped into fill, drain
// and noise phases. A bench-side model of the ring predicts every result
// not pinned in the table, and each returned result is compared field by field, in order.
// -----------------------------------------------------------------------------
module tb_timestamped_sample_ring_overwrite;

    import tsro_pkg::*;

    localparam int RING_DEPTH     = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 750;
    localparam int CALM_TAIL      = 120;  // last requests run with no idling
    localparam int PAUSE_AT       = 400;  // sender waits until no result is owed here
    localparam int WATCHDOG_LIMIT = 2000;

    // Opcodes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    // One result as the block reports it
    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] stamp;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  dropped;
        logic [6:0]        level;
    } ring_result_t;

    // One row of the directed table; pinned rows carry a hand-written result
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        logic [MASK_W-1:0] pins;
        logic [TIME_W-1:0] bound;
        logic              pinned;
        ring_result_t      want;
    } script_row_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_NOISE} phase_e;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [OP_W-1:0]                  opcode;
    logic [TIME_W-1:0]                sample_time;
    logic [MASK_W-1:0]                sensor_pins;
    logic [TIME_W-1:0]                bound_time;
    logic                             out_valid;
    logic                             out_stall;
    logic                             entry_valid;
    logic [TIME_W-1:0]                entry_time;
    logic [MASK_W-1:0]                entry_mask;
    logic [CNT_W-1:0]                 overwrite_total;
    logic [$clog2(RING_DEPTH+1)-1:0]  fill_level;

    timestamped_sample_ring_overwrite #(
        .QUEUE_DEPTH (RING_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .sample_time     (sample_time),
        .sensor_pins     (sensor_pins),
        .bound_time      (bound_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .entry_valid     (entry_valid),
        .entry_time      (entry_time),
        .entry_mask      (entry_mask),
        .overwrite_total (overwrite_total),
        .fill_level      (fill_level)
    );

    // -------------------------------------------------------------------------
    // Bench-side copy of the ring state
    // -------------------------------------------------------------------------
    logic [TIME_W-1:0] ring_time [RING_DEPTH];
    logic [MASK_W-1:0] ring_mask [RING_DEPTH];
    int                wr_slot      = 0;
    int                rd_slot      = 0;
    int                held         = 0;
    logic [CNT_W-1:0]  dropped      = '0;
    logic              armed        = 1'b0;

    ring_result_t      ring_expect [$];   // results still owed by the block
    script_row_t       script [$];

    int                gap_odds     = 0;  // percent chance of a sender gap
    int                stall_odds   = 0;  // percent chance of a receiver stall
    int                sent_total   = 0;
    int                results_seen = 0;
    int                entries_out  = 0;
    int                mismatches   = 0;
    int                peak_fill    = 0;
    int                overwrites   = 0;
    int                idle_cycles  = 0;
    logic [TIME_W-1:0] clock_ms;

    // -------------------------------------------------------------------------
    // Clock
    // -------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -------------------------------------------------------------------------
    // Predict the result of one accepted request and advance the ring copy
    // -------------------------------------------------------------------------
    function automatic ring_result_t predict_ring(input logic [OP_W-1:0] op,
                                                  input logic [TIME_W-1:0] stamp,
                                                  input logic [MASK_W-1:0] pins,
                                                  input logic [TIME_W-1:0] bound);
        ring_result_t r;
        logic [TIME_W-1:0] diff;
        r = '0;
        case (op)
            OP_SAMPLE:
            begin
                // Samples only count once a start has armed the ring
                if (armed)
                begin
                    if (held >= RING_DEPTH)
                    begin
                        // Full: drop the oldest entry to make room
                        rd_slot = (rd_slot + 1) % RING_DEPTH;
                        held--;
                        dropped++;
                        overwrites++;
                    end
                    ring_time[wr_slot] = stamp;
                    ring_mask[wr_slot] = ~pins;
                    wr_slot = (wr_slot + 1) % RING_DEPTH;
                    held++;
                    if (held > peak_fill)
                        peak_fill = held;
                end
            end
            OP_POP, OP_POP_BOUND:
            begin
                if (held != 0)
                begin
                    // Entry is too new only if the signed difference is positive
                    diff = ring_time[rd_slot] - bound;
                    if (op == OP_POP || diff == '0 || diff[TIME_W-1])
                    begin
                        r.hit   = 1'b1;
                        r.stamp = ring_time[rd_slot];
                        r.mask  = ring_mask[rd_slot];
                        rd_slot = (rd_slot + 1) % RING_DEPTH;
                        held--;
                    end
                end
            end
            OP_CLEAR, OP_START:
            begin
                wr_slot = 0;
                rd_slot = 0;
                held    = 0;
                dropped = '0;
                if (op == OP_START)
                    armed = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.dropped = dropped;
        r.level   = 7'(held);
        return r;
    endfunction

    function automatic script_row_t step_row(input logic [OP_W-1:0] op,
                                             input logic [TIME_W-1:0] stamp,
                                             input logic [MASK_W-1:0] pins,
                                             input logic [TIME_W-1:0] bound);
        script_row_t row;
        row        = '0;
        row.op     = op;
        row.stamp  = stamp;
        row.pins   = pins;
        row.bound  = bound;
        return row;
    endfunction

    function automatic script_row_t known_row(input logic [OP_W-1:0] op,
                                              input logic [TIME_W-1:0] stamp,
                                              input logic [MASK_W-1:0] pins,
                                              input logic [TIME_W-1:0] bound,
                                              input logic hit,
                                              input logic [TIME_W-1:0] got_time,
                                              input logic [MASK_W-1:0] got_mask,
                                              input logic [6:0] level);
        script_row_t row;
        row              = step_row(op, stamp, pins, bound);
        row.pinned       = 1'b1;
        row.want.hit     = hit;
        row.want.stamp   = got_time;
        row.want.mask    = got_mask;
        row.want.dropped = '0;
        row.want.level   = level;
        return row;
    endfunction

    // -------------------------------------------------------------------------
    // Choose a random request shaped by the current phase
    // -------------------------------------------------------------------------
    function automatic void pick_request(input phase_e phase,
                                         output logic [OP_W-1:0] op,
                                         output logic [TIME_W-1:0] stamp,
                                         output logic [MASK_W-1:0] pins,
                                         output logic [TIME_W-1:0] bound);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  op = (roll < 85) ? OP_SAMPLE : (roll < 93) ? OP_POP : OP_POP_BOUND;
            PH_DRAIN: op = (roll < 10) ? OP_SAMPLE : (roll < 50) ? OP_POP : OP_POP_BOUND;
            default:  op = 3'($urandom_range(0, 7));
        endcase
        // Advance a millisecond clock; now and then jump anywhere
        clock_ms = clock_ms + 32'($urandom_range(0, 20));
        stamp    = ($urandom_range(0, 9) == 0) ? 32'($urandom) : clock_ms;
        pins     = 4'($urandom_range(0, 15));
        // Aim most bounds within 3 ms of the oldest entry
        if (held != 0 && $urandom_range(0, 4) != 0)
            bound = ring_time[rd_slot] + 32'($urandom_range(0, 6)) - 32'd3;
        else
            bound = 32'($urandom);
    endfunction

    // -------------------------------------------------------------------------
    // Drive one request, hold it until accepted, then log its expected result
    // -------------------------------------------------------------------------
    task automatic send_request(input script_row_t row);
        ring_result_t predicted;
        // Insert a random sender gap
        if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= row.op;
        sample_time <= row.stamp;
        sensor_pins <= row.pins;
        bound_time  <= row.bound;
        // Hold the request until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_ring(row.op, row.stamp, row.pins, row.bound);
        ring_expect.push_back(row.pinned ? row.want : predicted);
        sent_total++;
    endtask

    task automatic flag_field(input string what,
                              input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    // -------------------------------------------------------------------------
    // Receiver: stall in random bursts
    // -------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // -------------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest expectation
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        ring_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (ring_expect.size() == 0)
            begin
                $display("%0t: result with none expected, got valid %0b time %0h",
                         $time, entry_valid, entry_time);
                mismatches++;
            end
            else
            begin
                want = ring_expect.pop_front();
                if (want.hit)
                    entries_out++;
                if (want.hit !== entry_valid)
                    flag_field("entry_valid", 32'(want.hit), 32'(entry_valid));
                if (want.stamp !== entry_time)
                    flag_field("entry_time", want.stamp, entry_time);
                if (want.mask !== entry_mask)
                    flag_field("entry_mask", 32'(want.mask), 32'(entry_mask));
                if (want.dropped !== overwrite_total)
                    flag_field("overwrite_total", want.dropped, overwrite_total);
                if (want.level !== fill_level)
                    flag_field("fill_level", 32'(want.level), 32'(fill_level));
            end
        end
    end

    // -------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("timestamped_sample_ring_overwrite: mismatch");
                $finish;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial
    begin : stimulus
        script_row_t  row;
        phase_e       phase;
        int           span;
        int           random_sent;
        int           odds_pick;
        bit           paused_once;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_SAMPLE;
        sample_time = '0;
        sensor_pins = '0;
        bound_time  = '0;
        clock_ms    = 32'($urandom);
        random_sent = 0;
        paused_once = 1'b0;

        // Empty ring and disarmed sampling right after reset
        script.push_back(known_row(OP_POP,       '0,  4'h0, '0,  1'b0, '0, 4'h0, 7'd0));
        script.push_back(known_row(OP_POP_BOUND, '0,  4'h0, '1,  1'b0, '0, 4'h0, 7'd0));
        script.push_back(known_row(OP_SAMPLE,    '1,  4'h0, '0,  1'b0, '0, 4'h0, 7'd0));
        // Unused opcodes leave everything alone
        script.push_back(known_row(OP_SPARE5,    '1,  4'hF, '1,  1'b0, '0, 4'h0, 7'd0));
        script.push_back(known_row(OP_SPARE6,    '0,  4'h0, '0,  1'b0, '0, 4'h0, 7'd0));
        script.push_back(known_row(OP_SPARE7,    '1,  4'hF, '1,  1'b0, '0, 4'h0, 7'd0));
        // Arm, then store both timestamp and pin extremes
        script.push_back(known_row(OP_START,     '0,  4'h0, '0,  1'b0, '0, 4'h0, 7'd0));
        script.push_back(known_row(OP_SAMPLE,    '0,  4'hF, '0,  1'b0, '0, 4'h0, 7'd1));
        script.push_back(known_row(OP_SAMPLE,    '1,  4'h0, '0,  1'b0, '0, 4'h0, 7'd2));
        script.push_back(known_row(OP_POP,       '0,  4'h0, '0,  1'b1, '0, 4'h0, 7'd1));
        script.push_back(known_row(OP_POP,       '0,  4'h0, '0,  1'b1, '1, 4'hF, 7'd0));
        script.push_back(known_row(OP_POP,       '0,  4'h0, '0,  1'b0, '0, 4'h0, 7'd0));
        // Bound just below, then equal to, the oldest timestamp
        script.push_back(step_row(OP_SAMPLE,    32'd100,        4'h5, '0));
        script.push_back(step_row(OP_POP_BOUND, '0,             4'h0, 32'd99));
        script.push_back(step_row(OP_POP_BOUND, '0,             4'h0, 32'd100));
        // Half-range difference counts as not later
        script.push_back(step_row(OP_SAMPLE,    32'h8000_0000,  4'hA, '0));
        script.push_back(step_row(OP_POP_BOUND, '0,             4'h0, '0));
        // Bound across the wrap: entry 5 is later than bound all-ones
        script.push_back(step_row(OP_SAMPLE,    32'd5,          4'h3, '0));
        script.push_back(step_row(OP_POP_BOUND, '0,             4'h0, '1));
        script.push_back(step_row(OP_SAMPLE,    32'h7FFF_FFFF,  4'hC, '0));
        // Clear empties the ring but keeps sampling armed
        script.push_back(known_row(OP_CLEAR,     '0,  4'h0, '0,  1'b0, '0, 4'h0, 7'd0));
        script.push_back(step_row(OP_SAMPLE,    32'd1234,       4'h9, '0));
        script.push_back(step_row(OP_POP_BOUND, '0,             4'h0, 32'd1233));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table with light idling on both sides
        gap_odds   = 20;
        stall_odds = 20;
        foreach (script[i])
            send_request(script[i]);

        // Random phases: fill to force overwrites, drain, and noise
        while (random_sent < RANDOM_ITEMS)
        begin
            phase = phase_e'($urandom_range(0, 2));
            case (phase)
                PH_FILL:  span = $urandom_range(50, 90);
                PH_DRAIN: span = $urandom_range(20, 60);
                default:  span = $urandom_range(10, 30);
            endcase
            // Pick idling per phase; some phases run flat out
            odds_pick  = $urandom_range(0, 2);
            gap_odds   = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 15 : 50;
            odds_pick  = $urandom_range(0, 2);
            stall_odds = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 15 : 50;
            // No idling once the tail of the run has begun
            if (RANDOM_ITEMS - random_sent <= CALM_TAIL)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end

            // Occasionally restart before a fill so the counter resets
            if (phase == PH_FILL && $urandom_range(0, 3) == 0)
            begin
                send_request(step_row(OP_START, 32'($urandom), 4'($urandom), 32'($urandom)));
                random_sent++;
            end

            for (int k = 0; k < span && random_sent < RANDOM_ITEMS; k++)
            begin
                // Drop all idling for the tail of the run
                if (RANDOM_ITEMS - random_sent <= CALM_TAIL)
                begin
                    gap_odds   = 0;
                    stall_odds = 0;
                end
                // Hold off once until every owed result has come back
                if (!paused_once && random_sent >= PAUSE_AT)
                begin
                    paused_once = 1'b1;
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (ring_expect.size() != 0)
                        @(posedge clk);
                end
                row = '0;
                pick_request(phase, row.op, row.stamp, row.pins, row.bound);
                send_request(row);
                random_sent++;
            end
        end

        // Drain the remaining results, then let the bench settle before the summary
        @(negedge clk);
        in_valid <= 1'b0;
        while (ring_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d requests and checked %0d results; %0d entries came back.",
                 sent_total, results_seen, entries_out);
        $display("Ring peaked at %0d entries and dropped %0d on overflow in all.",
                 peak_fill, overwrites);
        if (mismatches == 0)
            $display("timestamped_sample_ring_overwrite: match");
        else
            $display("timestamped_sample_ring_overwrite: mismatch");
        $finish;
    end

endmodule
